// ----- design/asrt_pkg.sv -----
// ----------------------------------------------------------------------------
// asrt_pkg: shared types and constants of the affine point transform
// Item structs, the register map, the setup sequencer states, the angle
// constants and the CORDIC arctangent values.
// ----------------------------------------------------------------------------
package asrt_pkg;

  localparam int unsigned COORD_W   = 32;
  localparam int unsigned ANGLE_W   = 17;
  localparam int unsigned ANG_RED_W = 19;
  localparam int unsigned TRIG_W    = 34;
  localparam int unsigned MAT_W     = 34;
  localparam int unsigned Z_W       = 32;
  localparam int unsigned STEP_W    = 5;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned PROD_W    = COORD_W + MAT_W;

  localparam int unsigned MID_DEPTH = 4;
  localparam int unsigned OUT_DEPTH = 4;

  // Angle register units are 1/128 degree.
  localparam logic signed [ANG_RED_W-1:0] ANGLE_TURN      = 19'sd46080;
  localparam logic signed [ANG_RED_W-1:0] ANGLE_TWO_TURNS = 19'sd92160;
  localparam logic signed [ANG_RED_W-1:0] ANGLE_HALF      = 19'sd23040;
  localparam logic signed [ANG_RED_W-1:0] ANGLE_QUARTER   = 19'sd11520;

  // CORDIC start value, the inverse gain in Q2.30.
  localparam logic signed [TRIG_W-1:0] CORDIC_GAIN = 34'sd652032874;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SCALE_X     = 3'd0,
    REG_SCALE_Y     = 3'd1,
    REG_ROTATE      = 3'd2,
    REG_TRANSLATE_X = 3'd3,
    REG_TRANSLATE_Y = 3'd4
  } cfg_reg_e;

  typedef enum logic [1:0] {
    ST_REDUCE,
    ST_ROTATE,
    ST_MATRIX,
    ST_READY
  } setup_state_e;

  typedef struct packed {
    logic signed [COORD_W-1:0] point_x;
    logic signed [COORD_W-1:0] point_y;
  } in_item_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] out_x;
    logic signed [COORD_W-1:0] out_y;
    logic                      clipped;
  } out_item_t;

  typedef struct packed {
    logic signed [MAT_W-1:0]   m00;
    logic signed [MAT_W-1:0]   m01;
    logic signed [MAT_W-1:0]   m10;
    logic signed [MAT_W-1:0]   m11;
    logic signed [COORD_W-1:0] trans_x;
    logic signed [COORD_W-1:0] trans_y;
  } matrix_t;

  // atan(2^-i) in units of 2^-22 degree, rounded to nearest.
  function automatic logic signed [Z_W-1:0] atan_deg22(input logic [STEP_W-1:0] i);
    logic signed [Z_W-1:0] val;
    case (i)
      5'd0:    val = 32'sd188743680;
      5'd1:    val = 32'sd111421900;
      5'd2:    val = 32'sd58872272;
      5'd3:    val = 32'sd29884485;
      5'd4:    val = 32'sd15000234;
      5'd5:    val = 32'sd7507429;
      5'd6:    val = 32'sd3754631;
      5'd7:    val = 32'sd1877430;
      5'd8:    val = 32'sd938729;
      5'd9:    val = 32'sd469366;
      5'd10:   val = 32'sd234683;
      5'd11:   val = 32'sd117342;
      5'd12:   val = 32'sd58671;
      5'd13:   val = 32'sd29335;
      5'd14:   val = 32'sd14668;
      5'd15:   val = 32'sd7334;
      5'd16:   val = 32'sd3667;
      5'd17:   val = 32'sd1833;
      5'd18:   val = 32'sd917;
      5'd19:   val = 32'sd458;
      5'd20:   val = 32'sd229;
      5'd21:   val = 32'sd115;
      5'd22:   val = 32'sd57;
      5'd23:   val = 32'sd29;
      5'd24:   val = 32'sd14;
      5'd25:   val = 32'sd7;
      5'd26:   val = 32'sd4;
      5'd27:   val = 32'sd2;
      5'd28:   val = 32'sd1;
      default: val = 32'sd0;
    endcase
    return val;
  endfunction

endpackage

// ----- design/affine_srt_point_transform.sv -----
// ----------------------------------------------------------------------------
// affine_srt_point_transform: 2D scale, rotate and translate of Q16.16 points
// Top level: configuration and matrix setup in front, a short point queue,
// the multiply pipeline in back and a result queue on the output side.
// ----------------------------------------------------------------------------
// The block takes one point per clock and returns one transformed point per
// point, in order, with a sustained rate of one item per cycle while full is
// low and the result queue is popped; the four point-by-matrix multipliers of
// the back pipeline run whenever it advances. A pushed point passes the point
// queue, the product registers and the rounded-product registers before it
// enters the result queue. The matrix is rebuilt after reset and after every
// configuration beat: angle reduction, then CORDIC_STEPS rotations of the
// CORDIC, then a phase in which one shared multiplier forms the four matrix
// entries, and full stays high until the rebuild is done. The configuration
// channel is always ready; registers are meant to be written only while no
// point is in flight. Each result carries a clipped flag that is set when
// either coordinate saturated to the 32-bit range.
// ----------------------------------------------------------------------------
module affine_srt_point_transform #(
  parameter int unsigned FRAC_BITS    = 16,
  parameter int unsigned CORDIC_STEPS = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // Point input queue side.
  input  logic                           push,
  output logic                           full,
  input  asrt_pkg::in_item_t             in_data_i,
  // Result queue side.
  output logic                           empty,
  input  logic                           pop,
  output asrt_pkg::out_item_t            out_data_o,
  // Configuration write channel.
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [asrt_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [asrt_pkg::COORD_W-1:0]   cfg_data_i
);

  asrt_pkg::matrix_t   matrix;
  asrt_pkg::in_item_t  mid_head;
  asrt_pkg::out_item_t back_item;

  logic busy;
  logic mid_full, mid_empty, mid_pop;
  logic out_full, out_push, out_ready, out_pop;

  // The front owns the registers and the matrix; while it rebuilds the
  // matrix no new point is let in.
  asrt_front #(
    .FRAC_BITS   (FRAC_BITS),
    .CORDIC_STEPS(CORDIC_STEPS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_valid_i(cfg_valid_i),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .cfg_ready_o(cfg_ready_o),
    .busy_o     (busy),
    .matrix_o   (matrix)
  );

  assign full = busy || mid_full;

  // The point queue decouples the input side from stalls in the back.
  asrt_fifo #(
    .WIDTH($bits(asrt_pkg::in_item_t)),
    .DEPTH(asrt_pkg::MID_DEPTH)
  ) u_mid_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push && !full),
    .wdata_i(in_data_i),
    .pop_i  (mid_pop),
    .rdata_o(mid_head),
    .full_o (mid_full),
    .empty_o(mid_empty)
  );

  // The back pipeline advances whenever its last stage can hand its beat to
  // the result queue, including a full queue that is popped this cycle.
  assign out_pop   = pop && !empty;
  assign out_ready = !out_full || out_pop;

  asrt_back #(
    .FRAC_BITS(FRAC_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .matrix_i    (matrix),
    .head_i      (mid_head),
    .head_valid_i(!mid_empty),
    .head_pop_o  (mid_pop),
    .out_ready_i (out_ready),
    .out_push_o  (out_push),
    .out_item_o  (back_item)
  );

  asrt_fifo #(
    .WIDTH($bits(asrt_pkg::out_item_t)),
    .DEPTH(asrt_pkg::OUT_DEPTH)
  ) u_out_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (out_push),
    .wdata_i(back_item),
    .pop_i  (pop),
    .rdata_o(out_data_o),
    .full_o (out_full),
    .empty_o(empty)
  );

`ifndef NO_ASSERTIONS
  // A configuration beat must lock out points while the matrix is rebuilt.
  a_cfg_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cfg_valid_i && cfg_ready_o) |=> full)
    else $error("input not blocked after a configuration beat");

  // An accepted point is waiting in the point queue on the next cycle.
  a_point_queued: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !full) |=> !mid_empty)
    else $error("accepted point missing from the point queue");

  // A result handed to the result queue is visible on the next cycle.
  a_result_queued: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_push |=> !empty)
    else $error("result missing from the result queue");
`endif

endmodule

// ----- design/asrt_fifo.sv -----
// ----------------------------------------------------------------------------
// asrt_fifo: small register queue
// First-in first-out store with a combinational head; a push into a full
// queue is taken when a pop happens in the same cycle.
// ----------------------------------------------------------------------------
module asrt_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             pop_i,
  output logic [WIDTH-1:0] rdata_o,
  output logic             full_o,
  output logic             empty_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] cnt_q;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CNT_W'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_pop  = pop_i && !empty_o;
  assign do_push = push_i && (!full_o || do_pop);
  assign rdata_o = mem_q[rd_ptr_q];

  function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) wr_ptr_q <= next_ptr(wr_ptr_q);
      if (do_pop)  rd_ptr_q <= next_ptr(rd_ptr_q);
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_ptr_q] <= wdata_i;
  end

endmodule

// ----- design/asrt_front.sv -----
// ----------------------------------------------------------------------------
// asrt_front: configuration registers and matrix setup
// Holds the registers and, after reset and after every write, reduces the
// angle, runs the CORDIC one rotation per cycle and forms the four matrix
// entries through one shared multiplier.
// ----------------------------------------------------------------------------
module asrt_front #(
  parameter int unsigned FRAC_BITS    = 16,
  parameter int unsigned CORDIC_STEPS = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_valid_i,
  input  logic [asrt_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [asrt_pkg::COORD_W-1:0]        cfg_data_i,
  output logic                                cfg_ready_o,
  output logic                                busy_o,
  output asrt_pkg::matrix_t                   matrix_o
);

  localparam logic signed [asrt_pkg::COORD_W-1:0] SCALE_ONE = 32'sd1 <<< FRAC_BITS;
  localparam logic [asrt_pkg::STEP_W-1:0] LAST_STEP = asrt_pkg::STEP_W'(CORDIC_STEPS - 1);
  localparam logic [2:0] MAT_LAST = 3'd4;
  localparam logic signed [asrt_pkg::PROD_W-1:0] MAT_HALF = 66'sd1 <<< 29;

  asrt_pkg::setup_state_e state_q, state_d;

  logic signed [asrt_pkg::COORD_W-1:0] scale_x_q, scale_y_q, trans_x_q, trans_y_q;
  logic signed [asrt_pkg::ANGLE_W-1:0] rot_q;
  logic                                cfg_we;

  logic [asrt_pkg::STEP_W-1:0]         step_q;
  logic [2:0]                          mcnt_q;
  logic signed [asrt_pkg::TRIG_W-1:0]  x_q, y_q, x_n, y_n, dx, dy;
  logic signed [asrt_pkg::Z_W-1:0]     z_q, z_n, at;
  logic                                flip_q;

  logic signed [asrt_pkg::ANG_RED_W-1:0] a0, a1, a2, a3, a4;
  logic                                  fold_flip;

  logic signed [asrt_pkg::COORD_W-1:0] op_scale;
  logic signed [asrt_pkg::TRIG_W-1:0]  op_trig;
  logic signed [asrt_pkg::PROD_W-1:0]  prod_q, mr_full;
  logic signed [asrt_pkg::MAT_W-1:0]   mrnd;
  logic signed [asrt_pkg::MAT_W-1:0]   m00_q, m01_q, m10_q, m11_q;

  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_x_q <= SCALE_ONE;
      scale_y_q <= SCALE_ONE;
      rot_q     <= '0;
      trans_x_q <= '0;
      trans_y_q <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index_i)
        asrt_pkg::REG_SCALE_X:     scale_x_q <= cfg_data_i;
        asrt_pkg::REG_SCALE_Y:     scale_y_q <= cfg_data_i;
        asrt_pkg::REG_ROTATE:      rot_q     <= cfg_data_i[asrt_pkg::ANGLE_W-1:0];
        asrt_pkg::REG_TRANSLATE_X: trans_x_q <= cfg_data_i;
        asrt_pkg::REG_TRANSLATE_Y: trans_y_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Reduce the angle into [-90, 90] degrees and note whether it was folded.
  always_comb begin
    a0 = asrt_pkg::ANG_RED_W'(rot_q) + asrt_pkg::ANGLE_TWO_TURNS;
    a1 = (a0 >= asrt_pkg::ANGLE_TWO_TURNS) ? a0 - asrt_pkg::ANGLE_TWO_TURNS : a0;
    a2 = (a1 >= asrt_pkg::ANGLE_TURN) ? a1 - asrt_pkg::ANGLE_TURN : a1;
    a3 = (a2 >= asrt_pkg::ANGLE_HALF) ? a2 - asrt_pkg::ANGLE_TURN : a2;
    fold_flip = 1'b0;
    a4 = a3;
    if (a3 > asrt_pkg::ANGLE_QUARTER) begin
      a4 = a3 - asrt_pkg::ANGLE_HALF;
      fold_flip = 1'b1;
    end else if (a3 < -asrt_pkg::ANGLE_QUARTER) begin
      a4 = a3 + asrt_pkg::ANGLE_HALF;
      fold_flip = 1'b1;
    end
  end

  // One CORDIC rotation.
  always_comb begin
    dx = y_q >>> step_q;
    dy = x_q >>> step_q;
    at = asrt_pkg::atan_deg22(step_q);
    if (!z_q[asrt_pkg::Z_W-1]) begin
      x_n = x_q - dx;
      y_n = y_q + dy;
      z_n = z_q - at;
    end else begin
      x_n = x_q + dx;
      y_n = y_q - dy;
      z_n = z_q + at;
    end
  end

  // Matrix entry operands: cos and sin times the scale of their row.
  always_comb begin
    case (mcnt_q[1:0])
      2'd0:    begin op_scale = scale_x_q; op_trig = x_q; end
      2'd1:    begin op_scale = scale_x_q; op_trig = y_q; end
      2'd2:    begin op_scale = scale_y_q; op_trig = y_q; end
      default: begin op_scale = scale_y_q; op_trig = x_q; end
    endcase
    mr_full = (prod_q + MAT_HALF) >>> 30;
    mrnd    = $signed(mr_full[asrt_pkg::MAT_W-1:0]);
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      asrt_pkg::ST_REDUCE: state_d = asrt_pkg::ST_ROTATE;
      asrt_pkg::ST_ROTATE: if (step_q == LAST_STEP) state_d = asrt_pkg::ST_MATRIX;
      asrt_pkg::ST_MATRIX: if (mcnt_q == MAT_LAST) state_d = asrt_pkg::ST_READY;
      asrt_pkg::ST_READY:  state_d = asrt_pkg::ST_READY;
    endcase
    if (cfg_we) state_d = asrt_pkg::ST_REDUCE;
    busy_o = (state_q != asrt_pkg::ST_READY);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= asrt_pkg::ST_REDUCE;
      step_q  <= '0;
      mcnt_q  <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= (state_q == asrt_pkg::ST_ROTATE) ? step_q + asrt_pkg::STEP_W'(1) : '0;
      mcnt_q  <= (state_q == asrt_pkg::ST_MATRIX) ? mcnt_q + 3'd1 : '0;
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      asrt_pkg::ST_REDUCE: begin
        x_q    <= asrt_pkg::CORDIC_GAIN;
        y_q    <= '0;
        z_q    <= asrt_pkg::Z_W'(a4) <<< 15;
        flip_q <= fold_flip;
      end
      asrt_pkg::ST_ROTATE: begin
        z_q <= z_n;
        if (step_q == LAST_STEP && flip_q) begin
          x_q <= -x_n;
          y_q <= -y_n;
        end else begin
          x_q <= x_n;
          y_q <= y_n;
        end
      end
      asrt_pkg::ST_MATRIX: begin
        prod_q <= op_scale * op_trig;
        case (mcnt_q)
          3'd1:    m00_q <= mrnd;
          3'd2:    m01_q <= mrnd;
          3'd3:    m10_q <= -mrnd;
          3'd4:    m11_q <= mrnd;
          default: ;
        endcase
      end
      asrt_pkg::ST_READY: ;
    endcase
  end

  always_comb begin
    matrix_o.m00     = m00_q;
    matrix_o.m01     = m01_q;
    matrix_o.m10     = m10_q;
    matrix_o.m11     = m11_q;
    matrix_o.trans_x = trans_x_q;
    matrix_o.trans_y = trans_y_q;
  end

endmodule

// ----- design/asrt_back.sv -----
// ----------------------------------------------------------------------------
// asrt_back: point transform pipeline
// Two register stages (products, then rounded products) followed by the sum
// with the translation and saturation into the result queue.
// ----------------------------------------------------------------------------
module asrt_back #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  asrt_pkg::matrix_t   matrix_i,
  input  asrt_pkg::in_item_t  head_i,
  input  logic                head_valid_i,
  output logic                head_pop_o,
  input  logic                out_ready_i,
  output logic                out_push_o,
  output asrt_pkg::out_item_t out_item_o
);

  localparam int unsigned RND_W = asrt_pkg::PROD_W - FRAC_BITS;
  localparam int unsigned SUM_W = RND_W + 2;
  localparam logic signed [asrt_pkg::PROD_W-1:0] HALF = 66'sd1 <<< (FRAC_BITS - 1);

  logic en;
  logic s1_valid_q, s2_valid_q;

  logic signed [asrt_pkg::PROD_W-1:0] pxx_q, pyx_q, pxy_q, pyy_q;
  logic signed [RND_W-1:0]            rxx_q, ryx_q, rxy_q, ryy_q;
  logic signed [SUM_W-1:0]            sum_x, sum_y;
  logic                               over_x, under_x, over_y, under_y;

  function automatic logic signed [RND_W-1:0] round_prod(
    input logic signed [asrt_pkg::PROD_W-1:0] p
  );
    logic signed [asrt_pkg::PROD_W-1:0] t;
    t = (p + HALF) >>> FRAC_BITS;
    return $signed(t[RND_W-1:0]);
  endfunction

  assign en         = !s2_valid_q || out_ready_i;
  assign head_pop_o = en && head_valid_i;
  assign out_push_o = s2_valid_q && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else if (en) begin
      s1_valid_q <= head_valid_i;
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      pxx_q <= head_i.point_x * matrix_i.m00;
      pyx_q <= head_i.point_y * matrix_i.m10;
      pxy_q <= head_i.point_x * matrix_i.m01;
      pyy_q <= head_i.point_y * matrix_i.m11;
      rxx_q <= round_prod(pxx_q);
      ryx_q <= round_prod(pyx_q);
      rxy_q <= round_prod(pxy_q);
      ryy_q <= round_prod(pyy_q);
    end
  end

  always_comb begin
    sum_x = SUM_W'(rxx_q) + SUM_W'(ryx_q) + SUM_W'(matrix_i.trans_x);
    sum_y = SUM_W'(rxy_q) + SUM_W'(ryy_q) + SUM_W'(matrix_i.trans_y);
    over_x  = !sum_x[SUM_W-1] &&  (|sum_x[SUM_W-2:asrt_pkg::COORD_W-1]);
    under_x =  sum_x[SUM_W-1] && !(&sum_x[SUM_W-2:asrt_pkg::COORD_W-1]);
    over_y  = !sum_y[SUM_W-1] &&  (|sum_y[SUM_W-2:asrt_pkg::COORD_W-1]);
    under_y =  sum_y[SUM_W-1] && !(&sum_y[SUM_W-2:asrt_pkg::COORD_W-1]);
    if (over_x) begin
      out_item_o.out_x = 32'sh7fffffff;
    end else if (under_x) begin
      out_item_o.out_x = 32'sh80000000;
    end else begin
      out_item_o.out_x = $signed(sum_x[asrt_pkg::COORD_W-1:0]);
    end
    if (over_y) begin
      out_item_o.out_y = 32'sh7fffffff;
    end else if (under_y) begin
      out_item_o.out_y = 32'sh80000000;
    end else begin
      out_item_o.out_y = $signed(sum_y[asrt_pkg::COORD_W-1:0]);
    end
    out_item_o.clipped = over_x || under_x || over_y || under_y;
  end

endmodule

// ----- tb/affine_srt_point_transform_checker.sv -----
// ----------------------------------------------------------------------------
// affine_srt_point_transform_checker: result predictor and scoreboard
// Watches the point, result and register channels of the transform. It keeps
// its own copy of the five registers, computes the transformed point for
// every accepted input beat and compares each result beat with the oldest
// expected point.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module affine_srt_point_transform_checker #(
  parameter int unsigned FRAC_BITS    = 16,
  parameter int unsigned CORDIC_STEPS = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           push_i,
  input  logic                           full_i,
  input  asrt_pkg::in_item_t             point_i,
  input  logic                           empty_i,
  input  logic                           pop_i,
  input  asrt_pkg::out_item_t            result_i,
  input  logic                           cfg_valid_i,
  input  logic                           cfg_ready_i,
  input  logic [asrt_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [asrt_pkg::COORD_W-1:0]   cfg_data_i,
  output int                             pending_o,
  output int                             errors_o
);

  import asrt_pkg::*;

  localparam longint COORD_MAX = 64'sd2147483647;
  localparam longint COORD_MIN = -64'sd2147483648;

  // Arctangent of 2^-i in units of 2^-22 degree.
  longint arctan_table [0:31] = '{
    188743680, 111421900, 58872272, 29884485, 15000234, 7507429, 3754631,
    1877430, 938729, 469366, 234683, 117342, 58671, 29335, 14668, 7334,
    3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7, 4, 2, 1, 0, 0, 0
  };

  logic signed [COORD_W-1:0] scale_x_q;
  logic signed [COORD_W-1:0] scale_y_q;
  logic signed [ANGLE_W-1:0] angle_q;
  logic signed [COORD_W-1:0] shift_x_q;
  logic signed [COORD_W-1:0] shift_y_q;

  out_item_t expected_points [$];
  out_item_t oldest;
  int        mismatches = 0;

  // Cosine and sine of the current angle in Q2.30.
  function automatic void cos_sin(output longint cos_v, output longint sin_v);
    longint a, x, y, z, dx, dy;
    logic   flip;
    int     i;
    a = longint'(angle_q);
    a = (a + longint'(ANGLE_TWO_TURNS)) % longint'(ANGLE_TURN);
    if (a >= longint'(ANGLE_HALF)) a = a - longint'(ANGLE_TURN);
    flip = 1'b0;
    // Outside +-90 degrees the CORDIC does not converge, so fold by half a
    // turn and negate both outputs.
    if (a > longint'(ANGLE_QUARTER)) begin
      a = a - longint'(ANGLE_HALF);
      flip = 1'b1;
    end else if (a < -longint'(ANGLE_QUARTER)) begin
      a = a + longint'(ANGLE_HALF);
      flip = 1'b1;
    end
    z = a * 32768;
    x = longint'(CORDIC_GAIN);
    y = 0;
    for (i = 0; i < CORDIC_STEPS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x = x - dx;
        y = y + dy;
        z = z - arctan_table[i];
      end else begin
        x = x + dx;
        y = y - dy;
        z = z + arctan_table[i];
      end
    end
    cos_v = flip ? -x : x;
    sin_v = flip ? -y : y;
  endfunction

  function automatic longint matrix_entry(input longint scale, input longint trig);
    return (scale * trig + (longint'(1) <<< 29)) >>> 30;
  endfunction

  function automatic longint round_product(input longint p, input longint m);
    return (p * m + (longint'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
  endfunction

  function automatic logic [COORD_W-1:0] clamp_coord(input longint v, output logic hit);
    hit = 1'b0;
    if (v > COORD_MAX) begin
      hit = 1'b1;
      v   = COORD_MAX;
    end else if (v < COORD_MIN) begin
      hit = 1'b1;
      v   = COORD_MIN;
    end
    return v[COORD_W-1:0];
  endfunction

  function automatic out_item_t transform_point(input in_item_t p);
    longint    c, s, m00, m01, m10, m11, px, py;
    logic      hit_x, hit_y;
    out_item_t r;
    cos_sin(c, s);
    m00 = matrix_entry(longint'(scale_x_q), c);
    m01 = matrix_entry(longint'(scale_x_q), s);
    m10 = -matrix_entry(longint'(scale_y_q), s);
    m11 = matrix_entry(longint'(scale_y_q), c);
    px  = longint'(p.point_x);
    py  = longint'(p.point_y);
    r.out_x = clamp_coord(round_product(px, m00) + round_product(py, m10)
                          + longint'(shift_x_q), hit_x);
    r.out_y = clamp_coord(round_product(px, m01) + round_product(py, m11)
                          + longint'(shift_y_q), hit_y);
    r.clipped = hit_x | hit_y;
    return r;
  endfunction

  task automatic check_field(input string name, input longint want, input longint got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_x_q <= 32'sd1 <<< FRAC_BITS;
      scale_y_q <= 32'sd1 <<< FRAC_BITS;
      angle_q   <= '0;
      shift_x_q <= '0;
      shift_y_q <= '0;
      expected_points.delete();
      pending_o <= 0;
      errors_o  <= 0;
    end else begin
      // A result beat leaves first: it always belongs to an earlier point.
      if (pop_i && !empty_i) begin
        if (expected_points.size() == 0) begin
          $display("%0t: result beat with no point waiting, actual x %0d y %0d clipped %0d",
                   $time, result_i.out_x, result_i.out_y, result_i.clipped);
          mismatches++;
        end else begin
          oldest = expected_points.pop_front();
          check_field("out_x", longint'(oldest.out_x), longint'(result_i.out_x));
          check_field("out_y", longint'(oldest.out_y), longint'(result_i.out_y));
          check_field("clipped", longint'(oldest.clipped), longint'(result_i.clipped));
        end
      end
      if (push_i && !full_i) expected_points.push_back(transform_point(point_i));
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          REG_SCALE_X:     scale_x_q <= cfg_data_i;
          REG_SCALE_Y:     scale_y_q <= cfg_data_i;
          REG_ROTATE:      angle_q   <= cfg_data_i[ANGLE_W-1:0];
          REG_TRANSLATE_X: shift_x_q <= cfg_data_i;
          REG_TRANSLATE_Y: shift_y_q <= cfg_data_i;
          default: ;
        endcase
      end
      pending_o <= expected_points.size();
      errors_o  <= mismatches;
    end
  end

endmodule

// ----- tb/affine_srt_point_transform_tb.sv -----
// ----------------------------------------------------------------------------
// affine_srt_point_transform_tb: stimulus and verdict for the point transform
// Drives points in random bursts and pops results on a stall pattern, walks
// the registers through directed and random settings while the block is
// idle, and leaves prediction and comparison to the checker beside the block.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module affine_srt_point_transform_tb;

  import asrt_pkg::*;

  localparam int unsigned FRAC_BITS    = 16;
  localparam int unsigned CORDIC_STEPS = 16;

  // Stimulus size and run limits. The longest quiet stretch of a correct run
  // is a matrix rebuild plus a receiver stall and a sender gap, far below the
  // watchdog limit.
  localparam int TOTAL_POINTS = 1050;
  localparam int IDLE_LIMIT   = 1000;
  localparam int DRAIN_CYCLES = 8;

  // Indexes past the last register; writes to them must change nothing.
  localparam logic [CFG_IDX_W-1:0] FIRST_UNMAPPED = CFG_IDX_W'(REG_TRANSLATE_Y + 1);

  // Receiver behavior for one stretch of cycles.
  typedef enum logic [1:0] {
    POP_ALWAYS,
    POP_MOSTLY,
    POP_EVERY_THIRD,
    POP_HOLD
  } pop_mode_e;

  logic                   clk       = 1'b0;
  logic                   rst_n     = 1'b0;
  logic                   push      = 1'b0;
  logic                   full;
  in_item_t               in_data   = '0;
  logic                   empty;
  logic                   pop       = 1'b0;
  out_item_t              out_data;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_index = '0;
  logic [COORD_W-1:0]     cfg_data  = '0;

  int pending;
  int errors;
  int points_sent = 0;
  int burst_left  = 0;
  int idle_cycles = 0;

  pop_mode_e pop_mode    = POP_ALWAYS;
  int        pop_left    = 0;
  int        pop_counter = 0;

  affine_srt_point_transform #(
    .FRAC_BITS   (FRAC_BITS),
    .CORDIC_STEPS(CORDIC_STEPS)
  ) uut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .push       (push),
    .full       (full),
    .in_data_i  (in_data),
    .empty      (empty),
    .pop        (pop),
    .out_data_o (out_data),
    .cfg_valid_i(cfg_valid),
    .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index),
    .cfg_data_i (cfg_data)
  );

  affine_srt_point_transform_checker #(
    .FRAC_BITS   (FRAC_BITS),
    .CORDIC_STEPS(CORDIC_STEPS)
  ) transform_check (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .push_i     (push),
    .full_i     (full),
    .point_i    (in_data),
    .empty_i    (empty),
    .pop_i      (pop),
    .result_i   (out_data),
    .cfg_valid_i(cfg_valid),
    .cfg_ready_i(cfg_ready),
    .cfg_index_i(cfg_index),
    .cfg_data_i (cfg_data),
    .pending_o  (pending),
    .errors_o   (errors)
  );

  // 4 ns clock, two equal halves.
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // The receiver switches between stretches of steady popping, random
  // popping, sparse periodic popping and holding off entirely. Each
  // stretch has a random length, so stalls land on every phase of the
  // result queue's fill level.
  always @(posedge clk) begin
    if (!rst_n) begin
      pop <= 1'b0;
    end else begin
      if (pop_left == 0) begin
        pop_mode = pop_mode_e'($urandom_range(0, 3));
        pop_left = (pop_mode == POP_HOLD) ? $urandom_range(1, 16) : $urandom_range(4, 40);
      end
      pop_left--;
      pop_counter++;
      case (pop_mode)
        POP_ALWAYS:      pop <= 1'b1;
        POP_MOSTLY:      pop <= ($urandom_range(0, 3) != 0);
        POP_EVERY_THIRD: pop <= (pop_counter % 3 == 0);
        default:         pop <= 1'b0;
      endcase
    end
  end

  // Watchdog: any beat on any channel counts as progress.
  always @(posedge clk) begin
    if (!rst_n) begin
      idle_cycles <= 0;
    end else if ((push && !full) || (pop && !empty) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : watchdog
    wait (idle_cycles >= IDLE_LIMIT);
    $display("TB_ERROR");
    $finish;
  end

  // Offers one point and holds it until the block takes it. The sender works
  // in bursts: push stays high across a burst and drops only for a gap
  // between bursts, so it is never lowered and raised in the same step.
  task automatic send_point(input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y);
    int gap;
    push    <= 1'b1;
    in_data <= {x, y};
    @(posedge clk);
    while (full) @(posedge clk);
    points_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = $urandom_range(0, 10);
      if (gap > 0) begin
        push <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(0, 40);
    end
  endtask

  // Stops offering points and waits until every expected result has been
  // popped. The first wait lets the checker's registered count catch up with
  // the last point taken.
  task automatic wait_idle();
    push <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // One register beat. Valid stays high so that beats can follow back to
  // back; the caller drops it after the last one.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [COORD_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic write_all(input logic [COORD_W-1:0] sx, input logic [COORD_W-1:0] sy,
                           input logic [COORD_W-1:0] ang, input logic [COORD_W-1:0] tx,
                           input logic [COORD_W-1:0] ty);
    write_reg(REG_SCALE_X, sx);
    write_reg(REG_SCALE_Y, sy);
    write_reg(REG_ROTATE, ang);
    write_reg(REG_TRANSLATE_X, tx);
    write_reg(REG_TRANSLATE_Y, ty);
  endtask

  // Mostly points within +-256.0 so that results rarely saturate, with some
  // full-range values and the corner values mixed in.
  function automatic logic [COORD_W-1:0] rand_coord();
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 4))
          0:       return 32'h7FFF_FFFF;
          1:       return 32'h8000_0000;
          2:       return 32'h0000_0000;
          3:       return 32'h0001_0000;
          default: return 32'hFFFF_FFFF;
        endcase
      end
      1, 2:    return $urandom();
      default: return 32'(int'($urandom_range(0, 33554431)) - 16777216);
    endcase
  endfunction

  // Scales mostly within +-4.0, sometimes zero, the extremes or anything.
  function automatic logic [COORD_W-1:0] rand_scale();
    case ($urandom_range(0, 9))
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2:       return 32'h0000_0000;
      3:       return $urandom();
      default: return 32'(int'($urandom_range(0, 524288)) - 262144);
    endcase
  endfunction

  // Angles: any 32-bit word (only the low 17 bits count, so this reaches
  // values beyond a full turn), exact right angles, values right at the
  // quarter and half turn folds, and plain angles within one turn.
  function automatic logic [COORD_W-1:0] rand_angle();
    int base;
    int sign;
    case ($urandom_range(0, 5))
      0:       return $urandom();
      1:       return 32'(11520 * (int'($urandom_range(0, 8)) - 4));
      2: begin
        base = 11520 * int'($urandom_range(1, 2));
        sign = ($urandom_range(0, 1) != 0) ? 1 : -1;
        return 32'(sign * base + int'($urandom_range(0, 2)) - 1);
      end
      default: return 32'(int'($urandom_range(0, 92160)) - 46080);
    endcase
  endfunction

  function automatic logic [COORD_W-1:0] rand_shift();
    case ($urandom_range(0, 9))
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2:       return $urandom();
      default: return 32'(int'($urandom_range(0, 536870912)) - 268435456);
    endcase
  endfunction

  // A random subset of the registers gets new values, now and then with a
  // write to an unmapped index thrown in.
  task automatic random_setup();
    if ($urandom_range(0, 3) != 0) write_reg(REG_SCALE_X, rand_scale());
    if ($urandom_range(0, 3) != 0) write_reg(REG_SCALE_Y, rand_scale());
    if ($urandom_range(0, 3) != 0) write_reg(REG_ROTATE, rand_angle());
    if ($urandom_range(0, 3) != 0) write_reg(REG_TRANSLATE_X, rand_shift());
    if ($urandom_range(0, 3) != 0) write_reg(REG_TRANSLATE_Y, rand_shift());
    if ($urandom_range(0, 5) == 0)
      write_reg(CFG_IDX_W'(FIRST_UNMAPPED + $urandom_range(0, 2)), $urandom());
    cfg_valid <= 1'b0;
  endtask

  initial begin : stimulus
    int phase_len;
    int k;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Reset settings are the identity: corner points, a half-unit value that
    // exercises rounding, and alternating bit patterns.
    send_point(32'h0000_0000, 32'h0000_0000);
    send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_point(32'h8000_0000, 32'h8000_0000);
    send_point(32'h0000_8000, 32'hFFFF_8000);
    send_point(32'h5555_5555, 32'hAAAA_AAAA);
    wait_idle();

    // Extreme scales and translations at a right angle: both coordinates
    // overflow in either direction and must saturate with the clipped flag.
    write_all(32'h7FFF_FFFF, 32'h8000_0000, 32'd11520, 32'h7FFF_FFFF, 32'h8000_0000);
    cfg_valid <= 1'b0;
    send_point(32'h7FFF_FFFF, 32'h8000_0000);
    send_point(32'h8000_0000, 32'h7FFF_FFFF);
    send_point(32'h0000_0000, 32'h0000_0000);
    send_point(32'h0001_0000, 32'hFFFF_0000);
    wait_idle();

    // The angle field gets its most negative value, well past a full turn,
    // and the scale is -1.0.
    write_all(32'hFFFF_0000, 32'hFFFF_0000, 32'hFFFF_0000, 32'h0, 32'h0);
    cfg_valid <= 1'b0;
    send_point(32'h0001_0000, 32'h0000_0000);
    send_point(32'h0000_0000, 32'h0001_0000);
    send_point(32'h1234_5678, 32'h8765_4321);
    wait_idle();

    // Most positive angle field, uneven scales and fractional translations.
    write_all(32'h0002_0000, 32'h0000_8000, 32'h0000_FFFF, 32'h0001_8000, 32'hFFFE_8000);
    cfg_valid <= 1'b0;
    send_point(32'h0001_0000, 32'h0001_0000);
    send_point(32'hFFFF_0000, 32'h0003_0000);
    send_point(32'h7FFF_FFFF, 32'h0000_0001);
    wait_idle();

    // Exactly minus half a turn, then writes to every unmapped index that
    // must leave the settings alone.
    write_all(32'h0001_0000, 32'h0001_0000, -32'sd23040, 32'h0, 32'h0);
    write_reg(FIRST_UNMAPPED, 32'hFFFF_FFFF);
    write_reg(CFG_IDX_W'(FIRST_UNMAPPED + 1), 32'hFFFF_FFFF);
    write_reg(CFG_IDX_W'(FIRST_UNMAPPED + 2), 32'hFFFF_FFFF);
    cfg_valid <= 1'b0;
    send_point(32'h7FFF_FFFF, 32'h0000_0000);
    send_point(32'h0000_0000, 32'h8000_0000);
    send_point(32'h0001_0000, 32'h0001_0000);
    wait_idle();

    // Just past a quarter turn, the first angle that folds.
    write_reg(REG_ROTATE, 32'd11521);
    cfg_valid <= 1'b0;
    send_point(32'h0001_0000, 32'h0000_0000);
    send_point(32'h0000_0000, 32'h0001_0000);
    wait_idle();

    // Random phases: new settings while idle, then a run of random points.
    while (points_sent < TOTAL_POINTS) begin
      random_setup();
      phase_len = $urandom_range(40, 120);
      for (k = 0; k < phase_len && points_sent < TOTAL_POINTS; k++) begin
        send_point(rand_coord(), rand_coord());
      end
      wait_idle();
    end

    // Anything arriving late would show up as a result with no point waiting.
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ----- affine_srt_point_transform.f -----
design/asrt_pkg.sv
design/asrt_fifo.sv
design/asrt_front.sv
design/asrt_back.sv
design/affine_srt_point_transform.sv
tb/affine_srt_point_transform_checker.sv
tb/affine_srt_point_transform_tb.sv
